>>> rtl/srclip_pkg.sv
`default_nettype none
package srclip_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int COORD_BITS  = 16;

  localparam int WORD_COORD_BITS = 16;
  localparam int SIZE_BITS       = 13;
  localparam int INDEX_BITS      = 8;
  localparam int PROD_BITS       = INDEX_BITS + SIZE_BITS;
  localparam int CALC_BITS       = PROD_BITS + 2;
  localparam int IDX_BITS        = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_BITS        = $clog2(MAX_REGIONS + 1);
  localparam int ENTRY_BITS      = 4 * COORD_BITS;
  localparam int CFG_INDEX_BITS  = 3;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STRIP_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STRIP_HEIGHT    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STRIPS_VERTICAL = 3'd4;

  typedef struct packed {
    logic [1:0]                        func;
    logic signed [WORD_COORD_BITS-1:0] region_left;
    logic signed [WORD_COORD_BITS-1:0] region_top;
    logic signed [WORD_COORD_BITS-1:0] region_right;
    logic signed [WORD_COORD_BITS-1:0] region_bottom;
    logic                              refresh_all;
    logic [INDEX_BITS-1:0]             strip_index;
  } in_word_t;

  typedef struct packed {
    logic                              accepted;
    logic                              render;
    logic signed [WORD_COORD_BITS-1:0] clip_left;
    logic signed [WORD_COORD_BITS-1:0] clip_top;
    logic signed [WORD_COORD_BITS-1:0] clip_right;
    logic signed [WORD_COORD_BITS-1:0] clip_bottom;
    logic                              buffer_select;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] l;
    logic signed [COORD_BITS-1:0] t;
    logic signed [COORD_BITS-1:0] r;
    logic signed [COORD_BITS-1:0] b;
  } region_t;

  typedef struct packed {
    logic signed [CALC_BITS-1:0] l;
    logic signed [CALC_BITS-1:0] t;
    logic signed [CALC_BITS-1:0] r;
    logic signed [CALC_BITS-1:0] b;
  } cbox_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage
`default_nettype wire

>>> rtl/strip_dirty_region_clipper.sv
`default_nettype none
// Start and add words never raise busy; their result strobes in the cycle after acceptance.
// A query holds busy through ST_MUL (strip origin), ST_CLIP (clip to screen), ST_CHECK and
// ST_SCAN (one step per stored region), then ST_FIN registers the result; an off-screen strip,
// full refresh or an empty table skips the scan and the result is registered from ST_CHECK.
// The region memory is read one entry per cycle; results cannot be stalled by the receiver.
// Synchronous active-low reset empties the table, clears the mark and loads default geometry.
module strip_dirty_region_clipper
  import srclip_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire in_word_t                  in_word,
  output logic                           out_strobe,
  output out_word_t                      out_word,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [SIZE_BITS-1:0]      cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_CLIP  = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SIZE_BITS-1:0]  scr_w_r, scr_h_r, strip_w_r, strip_h_r;
  logic                  vert_r;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic                  mark_r, mark_nxt;
  logic [IDX_BITS-1:0]   pos_r, pos_nxt;
  logic [INDEX_BITS-1:0] idx_r;
  cbox_t                 strip_r, strip_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_word_t             out_word_r, out_word_nxt;

  logic                  accept;
  logic                  we;
  region_t               wentry;
  logic [IDX_BITS-1:0]   raddr;
  logic [ENTRY_BITS-1:0] rdata;
  scan_ctl_t             scan_ctl;
  logic                  any;
  cbox_t                 acc;

  logic [PROD_BITS-1:0]       prod;
  logic [PROD_BITS-1:0]       prod_a, prod_b;
  logic signed [CALC_BITS-1:0] end_x, end_y, lim_x, lim_y;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  assign we = accept && (in_word.func == FUNC_ADD) &&
              (count_r < CNT_BITS'(MAX_REGIONS));
  assign wentry.l = in_word.region_left[COORD_BITS-1:0];
  assign wentry.t = in_word.region_top[COORD_BITS-1:0];
  assign wentry.r = in_word.region_right[COORD_BITS-1:0];
  assign wentry.b = in_word.region_bottom[COORD_BITS-1:0];
  assign raddr = (state_r == ST_SCAN) ? pos_r + IDX_BITS'(1) : '0;

  srclip_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(MAX_REGIONS)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (count_r[IDX_BITS-1:0]),
    .wdata  (wentry),
    .raddr  (raddr),
    .rdata_r(rdata)
  );

  srclip_scan u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (scan_ctl),
    .strip(strip_r),
    .entry(region_t'(rdata)),
    .any_r(any),
    .acc_r(acc)
  );

  assign prod_a = {{(PROD_BITS-INDEX_BITS){1'b0}}, idx_r};
  assign prod_b = {{(PROD_BITS-SIZE_BITS){1'b0}}, (vert_r ? strip_w_r : strip_h_r)};
  assign prod  = prod_a * prod_b;
  assign end_x = strip_r.l + {{(CALC_BITS-SIZE_BITS){1'b0}}, strip_w_r} - CALC_BITS'(1);
  assign end_y = strip_r.t + {{(CALC_BITS-SIZE_BITS){1'b0}}, strip_h_r} - CALC_BITS'(1);
  assign lim_x = {{(CALC_BITS-SIZE_BITS){1'b0}}, scr_w_r} - CALC_BITS'(1);
  assign lim_y = {{(CALC_BITS-SIZE_BITS){1'b0}}, scr_h_r} - CALC_BITS'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    mark_nxt       = mark_r;
    pos_nxt        = pos_r;
    strip_nxt      = strip_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    scan_ctl.clear = 1'b0;
    scan_ctl.step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_word_nxt = '0;
          case (in_word.func)
            FUNC_START: begin
              count_nxt = '0;
              mark_nxt  = in_word.refresh_all;
              out_word_nxt.accepted = 1'b1;
              out_strobe_nxt = 1'b1;
            end
            FUNC_ADD: begin
              if (we) begin
                count_nxt = count_r + CNT_BITS'(1);
                out_word_nxt.accepted = 1'b1;
              end
              out_strobe_nxt = 1'b1;
            end
            FUNC_QUERY: begin
              state_nxt = ST_MUL;
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (vert_r) begin
          strip_nxt.l = {{(CALC_BITS-PROD_BITS){1'b0}}, prod};
          strip_nxt.t = '0;
        end else begin
          strip_nxt.l = '0;
          strip_nxt.t = {{(CALC_BITS-PROD_BITS){1'b0}}, prod};
        end
        state_nxt = ST_CLIP;
      end
      ST_CLIP: begin
        strip_nxt.r = (end_x < lim_x) ? end_x : lim_x;
        strip_nxt.b = (end_y < lim_y) ? end_y : lim_y;
        pos_nxt = '0;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        scan_ctl.clear = 1'b1;
        out_word_nxt = '0;
        out_word_nxt.buffer_select = idx_r[0];
        if ((strip_r.l > strip_r.r) || (strip_r.t > strip_r.b)) begin
          out_strobe_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else if (mark_r || (count_r == '0)) begin
          out_word_nxt.render      = 1'b1;
          out_word_nxt.clip_left   = strip_r.l[WORD_COORD_BITS-1:0];
          out_word_nxt.clip_top    = strip_r.t[WORD_COORD_BITS-1:0];
          out_word_nxt.clip_right  = strip_r.r[WORD_COORD_BITS-1:0];
          out_word_nxt.clip_bottom = strip_r.b[WORD_COORD_BITS-1:0];
          out_strobe_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_ctl.step = 1'b1;
        pos_nxt = pos_r + IDX_BITS'(1);
        if ({1'b0, pos_r} == CNT_BITS'(count_r - CNT_BITS'(1))) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        out_word_nxt = '0;
        out_word_nxt.buffer_select = idx_r[0];
        if (any) begin
          out_word_nxt.render      = 1'b1;
          out_word_nxt.clip_left   = acc.l[WORD_COORD_BITS-1:0];
          out_word_nxt.clip_top    = acc.t[WORD_COORD_BITS-1:0];
          out_word_nxt.clip_right  = acc.r[WORD_COORD_BITS-1:0];
          out_word_nxt.clip_bottom = acc.b[WORD_COORD_BITS-1:0];
        end
        out_strobe_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      mark_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      scr_w_r      <= SIZE_BITS'(480);
      scr_h_r      <= SIZE_BITS'(480);
      strip_w_r    <= SIZE_BITS'(480);
      strip_h_r    <= SIZE_BITS'(16);
      vert_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      mark_r       <= mark_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:    scr_w_r   <= cfg_data;
          CFG_SCREEN_HEIGHT:   scr_h_r   <= cfg_data;
          CFG_STRIP_WIDTH:     strip_w_r <= cfg_data;
          CFG_STRIP_HEIGHT:    strip_h_r <= cfg_data;
          CFG_STRIPS_VERTICAL: vert_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
    pos_r      <= pos_nxt;
    strip_r    <= strip_nxt;
    out_word_r <= out_word_nxt;
    if (accept) begin
      idx_r <= in_word.strip_index;
    end
  end

endmodule
`default_nettype wire

>>> rtl/srclip_ram.sv
`default_nettype none
module srclip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/srclip_scan.sv
`default_nettype none
module srclip_scan
  import srclip_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire scan_ctl_t ctl,
  input  wire cbox_t     strip,
  input  wire region_t   entry,
  output logic           any_r,
  output cbox_t          acc_r
);

  cbox_t g;
  cbox_t hit;
  logic  hit_ok;
  logic  any_nxt;
  cbox_t acc_nxt;

  always_comb begin
    g.l = {{(CALC_BITS-COORD_BITS){entry.l[COORD_BITS-1]}}, entry.l};
    g.t = {{(CALC_BITS-COORD_BITS){entry.t[COORD_BITS-1]}}, entry.t};
    g.r = {{(CALC_BITS-COORD_BITS){entry.r[COORD_BITS-1]}}, entry.r};
    g.b = {{(CALC_BITS-COORD_BITS){entry.b[COORD_BITS-1]}}, entry.b};
    hit.l = (strip.l > g.l) ? strip.l : g.l;
    hit.t = (strip.t > g.t) ? strip.t : g.t;
    hit.r = (strip.r < g.r) ? strip.r : g.r;
    hit.b = (strip.b < g.b) ? strip.b : g.b;
    hit_ok = (hit.l <= hit.r) && (hit.t <= hit.b);
    any_nxt = any_r;
    acc_nxt = acc_r;
    if (ctl.clear) begin
      any_nxt = 1'b0;
    end else if (ctl.step && hit_ok) begin
      any_nxt = 1'b1;
      if (!any_r) begin
        acc_nxt = hit;
      end else begin
        acc_nxt.l = (hit.l < acc_r.l) ? hit.l : acc_r.l;
        acc_nxt.t = (hit.t < acc_r.t) ? hit.t : acc_r.t;
        acc_nxt.r = (hit.r > acc_r.r) ? hit.r : acc_r.r;
        acc_nxt.b = (hit.b > acc_r.b) ? hit.b : acc_r.b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
    end else begin
      any_r <= any_nxt;
    end
    acc_r <= acc_nxt;
  end

endmodule
`default_nettype wire
